/* sv/fxrq_pkg.sv */
// shared types and constants for the xor fenwick tree range query core
// no dependencies
`default_nettype none

package fxrq_pkg;

	localparam int IDX_W  = 10;
	localparam int SIZE_W = 11;
	localparam int VAL_W  = 32;
	// tree node numbers run to twice the largest size
	localparam int NODE_W = SIZE_W + 1;

	localparam int MAX_SIZE_DEF   = 1024;
	localparam int WORD_WIDTH_DEF = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	typedef struct packed {
		logic              command;
		logic [IDX_W-1:0]  index_first;
		logic [IDX_W-1:0]  index_last;
		logic [VAL_W-1:0]  value;
	} fxrq_in_t;

	typedef struct packed {
		logic [VAL_W-1:0] xor_value;
		logic             range_error;
	} fxrq_out_t;

	typedef struct packed {
		logic clr_en;
		logic load;
		logic upd_start;
		logic qry_start;
		logic rd_en;
		logic upd_write;
		logic qry_step;
		logic load_first;
		logic set_err;
	} fxrq_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_query;
		logic upd_ok;
		logic qry_bad;
		logic node_zero;
		logic step_zero;
		logic up_over;
	} fxrq_status_t;

endpackage

`default_nettype wire

/* sv/fxrq_datapath.sv */
// tree memory, node walker, accumulator and size register
// depends on fxrq_pkg
`default_nettype none

module fxrq_datapath import fxrq_pkg::*; #(
	parameter int MAX_SIZE   = MAX_SIZE_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [SIZE_W-1:0] cfg_data,
	input  wire fxrq_in_t          request,
	input  wire fxrq_cmd_t         cmd,
	output fxrq_status_t           status,
	output fxrq_out_t              response
);

	localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam logic [AW-1:0] CLR_LAST = AW'(MAX_SIZE - 1);

	logic [WORD_WIDTH-1:0] mem [MAX_SIZE];

	logic [SIZE_W-1:0]     size_q;
	logic [SIZE_W-1:0]     eff_size;
	logic [AW-1:0]         clr_addr_q;
	logic                  command_q;
	logic [IDX_W-1:0]      first_q;
	logic [IDX_W-1:0]      last_q;
	logic [WORD_WIDTH-1:0] word_q;
	logic [NODE_W-1:0]     node_q;
	logic [NODE_W-1:0]     low_bit;
	logic [NODE_W-1:0]     node_up;
	logic [NODE_W-1:0]     node_down;
	logic [NODE_W-1:0]     node_m1;
	logic [NODE_W+AW-1:0]  node_ext;
	logic [AW-1:0]         node_addr;
	logic [WORD_WIDTH-1:0] rd_data_q;
	logic                  pend_q;
	logic [WORD_WIDTH-1:0] acc_q;
	logic                  err_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [WORD_WIDTH-1:0] mem_wdata;

	// sizes above the memory depth are clamped
	assign eff_size = (32'(size_q) > 32'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_q;

	assign low_bit   = node_q & (~node_q + NODE_W'(1));
	assign node_up   = node_q + low_bit;
	assign node_down = node_q - low_bit;
	assign node_m1   = node_q - NODE_W'(1);
	assign node_ext  = {{AW{1'b0}}, node_m1};
	assign node_addr = node_ext[AW-1:0];

	assign status.clr_done  = (clr_addr_q == CLR_LAST);
	assign status.is_query  = (command_q == CMD_QUERY);
	assign status.upd_ok    = ({1'b0, first_q} < eff_size);
	assign status.qry_bad   = (first_q > last_q) || ({1'b0, last_q} >= eff_size);
	assign status.node_zero = (node_q == '0);
	assign status.step_zero = (node_down == '0);
	assign status.up_over   = (node_up > {1'b0, eff_size});

	assign mem_we    = cmd.clr_en | cmd.upd_write;
	assign mem_waddr = cmd.clr_en ? clr_addr_q : node_addr;
	assign mem_wdata = cmd.clr_en ? '0 : (rd_data_q ^ word_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.rd_en | cmd.qry_step) begin
			rd_data_q <= mem[node_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			command_q <= request.command;
			first_q   <= request.index_first;
			last_q    <= request.index_last;
			word_q    <= WORD_WIDTH'(request.value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q     <= SIZE_RESET;
			clr_addr_q <= '0;
			node_q     <= '0;
			pend_q     <= 1'b0;
			acc_q      <= '0;
			err_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_data;
			end
			if (cmd.clr_en) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cmd.upd_start) begin
				node_q <= NODE_W'(first_q) + NODE_W'(1);
			end else if (cmd.qry_start) begin
				node_q <= NODE_W'(last_q) + NODE_W'(1);
			end else if (cmd.load_first) begin
				node_q <= NODE_W'(first_q);
			end else if (cmd.upd_write) begin
				node_q <= node_up;
			end else if (cmd.qry_step) begin
				node_q <= node_down;
			end
			// read data lands in the cycle after the query read
			pend_q <= cmd.qry_step;
			if (cmd.load) begin
				acc_q <= '0;
				err_q <= 1'b0;
			end else begin
				if (pend_q) begin
					acc_q <= acc_q ^ rd_data_q;
				end
				if (cmd.set_err) begin
					err_q <= 1'b1;
				end
			end
		end
	end

	assign response.xor_value   = VAL_W'(acc_q);
	assign response.range_error = err_q;

endmodule

`default_nettype wire

/* sv/fxrq_ctrl.sv */
// sequencer for memory clearing, update walks and query walks
// depends on fxrq_pkg
`default_nettype none

module fxrq_ctrl import fxrq_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire fxrq_status_t status,
	output fxrq_cmd_t         cmd,
	output logic              busy,
	output logic              result_valid
);

	typedef enum logic [8:0] {
		S_CLEAR  = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_CHECK  = 9'b000000100,
		S_UPD_RD = 9'b000001000,
		S_UPD_WR = 9'b000010000,
		S_QRY_A  = 9'b000100000,
		S_QRY_B  = 9'b001000000,
		S_DRAIN  = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (status.clr_done) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!status.is_query) begin
					if (status.upd_ok) begin
						cmd.upd_start = 1'b1;
						state_nxt     = S_UPD_RD;
					end else begin
						state_nxt = S_IDLE;
					end
				end else if (status.qry_bad) begin
					cmd.set_err = 1'b1;
					state_nxt   = S_DONE;
				end else begin
					cmd.qry_start = 1'b1;
					state_nxt     = S_QRY_A;
				end
			end
			S_UPD_RD: begin
				cmd.rd_en = 1'b1;
				state_nxt = S_UPD_WR;
			end
			S_UPD_WR: begin
				cmd.upd_write = 1'b1;
				state_nxt     = status.up_over ? S_IDLE : S_UPD_RD;
			end
			S_QRY_A: begin
				// prefix of length last+1, then switch to prefix of length first
				cmd.qry_step = 1'b1;
				if (status.step_zero) begin
					cmd.load_first = 1'b1;
					state_nxt      = S_QRY_B;
				end
			end
			S_QRY_B: begin
				if (status.node_zero) begin
					state_nxt = S_DRAIN;
				end else begin
					cmd.qry_step = 1'b1;
					if (status.step_zero) begin
						state_nxt = S_DRAIN;
					end
				end
			end
			S_DRAIN: begin
				state_nxt = S_DONE;
			end
			S_DONE: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = (state_q == S_DONE);

endmodule

`default_nettype wire

/* sv/fenwick_xor_range_query_core.sv */
// top level of the xor fenwick tree range query core
// depends on fxrq_pkg, fxrq_ctrl and fxrq_datapath
`default_nettype none

// An item is taken when start is high and busy is low. An update xors its value
// into one position and gives no result; a query gives one result, shown for a
// single cycle with result_valid high, and the receiver cannot hold it off.
// The tree is one memory with one read and one write per cycle, so cost follows
// the walks: an update reads and writes each node on its upward walk (at most
// log2(size)+1 nodes) and is dropped with no walk if its index is out of range;
// a query walks the popcount(last+1) nodes of one prefix and then the nodes of
// the prefix of length first, or sets range_error with no walk when the range
// is bad. After reset the block stays busy while it clears all MAX_SIZE memory
// words; size writes are taken at any time, but belong only to idle periods.

module fenwick_xor_range_query_core import fxrq_pkg::*; #(
	parameter int MAX_SIZE   = MAX_SIZE_DEF,
	parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire fxrq_in_t          request,
	output logic                   result_valid,
	output fxrq_out_t              response,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [SIZE_W-1:0] cfg_data
);

	fxrq_cmd_t    cmd;
	fxrq_status_t status;

	assign cfg_ready = 1'b1;

	fxrq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.status       (status),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	fxrq_datapath #(
		.MAX_SIZE   (MAX_SIZE),
		.WORD_WIDTH (WORD_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.request  (request),
		.cmd      (cmd),
		.status   (status),
		.response (response)
	);

endmodule

`default_nettype wire
